// File: src/ctpt_pkg.sv
// Shared constants and types for the circle-through-three-points core.
// Used by ctpt_sqrt_pipe and circle_through_three_points_core; depends on nothing.
package ctpt_pkg;

    localparam int RES_W   = 24;                 // width of each result field
    localparam int OUT_W   = 3 * RES_W;          // center_x, center_y, radius
    localparam int USER_W  = 2;                  // valid_res, clipped
    localparam int SQ_W    = 2 * RES_W + 1;      // sum of two squared offsets
    localparam int RT_W    = RES_W + 1;          // rounded root of SQ_W bits
    localparam int RES_SMAX = 2 ** (RES_W - 1) - 1;
    localparam int RES_SMIN = -(2 ** (RES_W - 1));
    localparam logic [RES_W-1:0] RES_UMAX = '1;

    // Data that rides along with the radius computation.
    typedef struct packed {
        logic [RES_W-1:0] cx;     // saturated center x
        logic [RES_W-1:0] cy;     // saturated center y
        logic             clip;   // a center coordinate saturated
        logic             big;    // an offset does not fit RES_W bits
        logic             gzero;  // collinear points
    } t_rad_side;

endpackage

// File: src/circle_through_three_points_core.sv
// Top level of the circle-through-three-points core: stream ports, back end, output register.
// Depends on ctpt_pkg, ctpt_geom, ctpt_div_pipe and ctpt_sqrt_pipe.

// This core takes one item of three pixel points per clock and returns the center and
// radius of the circle through them, in fixed point with FRAC_BITS fraction bits, rounded
// to nearest. A new item can enter every cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so a stalled output holds everything in place
// and nothing is dropped or repeated. The two center divisions produce one quotient bit
// per stage, and the square root adds one stage per root bit. Collinear points give
// valid_res low and all other fields zero. A center coordinate outside the signed 24-bit
// range saturates, a radius above the unsigned 24-bit range saturates, and clipped
// reports either. The radius is measured from the first point to the rounded,
// unsaturated center.
module circle_through_three_points_core #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y; zero padding on top
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // center_x, center_y, circle_radius
    output logic [ctpt_pkg::OUT_W-1:0]              m_axis_tdata,
    // valid_res, clipped
    output logic [ctpt_pkg::USER_W-1:0]             m_axis_tuser
);

    import ctpt_pkg::*;

    localparam int NUM_W = 3 * COORD_BITS + 6;        // center numerators
    localparam int GW    = 2 * COORD_BITS + 4;        // E, F and G
    localparam int QW    = NUM_W + FRAC_BITS + 3;     // signed rounded center
    localparam logic signed [QW-1:0] C_MAX = QW'(RES_SMAX);
    localparam logic signed [QW-1:0] C_MIN = QW'(RES_SMIN);

    logic ce;

    logic                       g_valid;
    logic signed [NUM_W-1:0]    g_num_x, g_num_y;
    logic signed [GW-1:0]       g_g;
    logic [COORD_BITS-1:0]      g_ax, g_ay;

    logic                       x_valid, y_valid, x_dz, y_dz;
    logic signed [QW-1:0]       x_quo, y_quo;
    logic [COORD_BITS-1:0]      x_ax, y_ay;

    logic signed [QW:0]         off_x, off_y;
    logic [QW:0]                mag_x, mag_y;
    logic [RES_W:0]             sat_x, sat_y;

    logic                       r_b1_v, r_b2_v, r_b3_v;
    t_rad_side                  r_b1_side, r_b2_side, r_b3_side;
    logic [RES_W-1:0]           r_b1_dx, r_b1_dy;
    logic [2*RES_W-1:0]         r_b2_sqx, r_b2_sqy;
    logic [SQ_W-1:0]            r_b3_sum;

    logic                       s_valid;
    logic [RT_W-1:0]            s_root;
    t_rad_side                  s_side;

    logic                       r_out_v;
    logic [OUT_W-1:0]           r_out_data;
    logic [USER_W-1:0]          r_out_user;
    logic [RES_W-1:0]           n_rad;
    logic                       n_clip;

    // One enable for the whole pipeline: advance unless the output item is held.
    assign ce            = !r_out_v || m_axis_tready;
    assign s_axis_tready = ce;

    ctpt_geom #(
        .COORD_BITS (COORD_BITS),
        .NUM_W      (NUM_W),
        .GW         (GW)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s_axis_tvalid),
        .i_ax    (s_axis_tdata[0*COORD_BITS +: COORD_BITS]),
        .i_ay    (s_axis_tdata[1*COORD_BITS +: COORD_BITS]),
        .i_bx    (s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
        .i_by    (s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
        .i_cx    (s_axis_tdata[4*COORD_BITS +: COORD_BITS]),
        .i_cy    (s_axis_tdata[5*COORD_BITS +: COORD_BITS]),
        .o_valid (g_valid),
        .o_num_x (g_num_x),
        .o_num_y (g_num_y),
        .o_g     (g_g),
        .o_ax    (g_ax),
        .o_ay    (g_ay)
    );

    // The x and y dividers run in lockstep; each carries the first point's matching
    // coordinate for the radius.
    ctpt_div_pipe #(
        .NUM_W     (NUM_W),
        .DEN_W     (GW),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (COORD_BITS)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (g_valid),
        .i_num   (g_num_x),
        .i_den   (g_g),
        .i_side  (g_ax),
        .o_valid (x_valid),
        .o_quo   (x_quo),
        .o_dzero (x_dz),
        .o_side  (x_ax)
    );

    ctpt_div_pipe #(
        .NUM_W     (NUM_W),
        .DEN_W     (GW),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (COORD_BITS)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (g_valid),
        .i_num   (g_num_y),
        .i_den   (g_g),
        .i_side  (g_ay),
        .o_valid (y_valid),
        .o_quo   (y_quo),
        .o_dzero (y_dz),
        .o_side  (y_ay)
    );

    // Saturate a center coordinate; the top bit of the result is the clip flag.
    function automatic logic [RES_W:0] f_sat(input logic signed [QW-1:0] v);
        logic [RES_W:0] res;
        if (v > C_MAX) begin
            res = {1'b1, C_MAX[RES_W-1:0]};
        end else if (v < C_MIN) begin
            res = {1'b1, C_MIN[RES_W-1:0]};
        end else begin
            res = {1'b0, v[RES_W-1:0]};
        end
        return res;
    endfunction

    // Offsets from the first point to the rounded center, in fraction units.
    always_comb begin
        off_x = $signed((QW + 1)'(x_ax) << FRAC_BITS) - (QW + 1)'(x_quo);
        off_y = $signed((QW + 1)'(y_ay) << FRAC_BITS) - (QW + 1)'(y_quo);
        mag_x = off_x[QW] ? $unsigned(-off_x) : $unsigned(off_x);
        mag_y = off_y[QW] ? $unsigned(-off_y) : $unsigned(off_y);
        sat_x = f_sat(x_quo);
        sat_y = f_sat(y_quo);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_b1_side.cx    <= sat_x[RES_W-1:0];
            r_b1_side.cy    <= sat_y[RES_W-1:0];
            r_b1_side.clip  <= sat_x[RES_W] | sat_y[RES_W];
            r_b1_side.big   <= (|mag_x[QW:RES_W]) | (|mag_y[QW:RES_W]);
            r_b1_side.gzero <= x_dz;
            r_b1_dx         <= mag_x[RES_W-1:0];
            r_b1_dy         <= mag_y[RES_W-1:0];

            r_b2_side <= r_b1_side;
            r_b2_sqx  <= r_b1_dx * r_b1_dx;
            r_b2_sqy  <= r_b1_dy * r_b1_dy;

            r_b3_side <= r_b2_side;
            r_b3_sum  <= SQ_W'(r_b2_sqx) + SQ_W'(r_b2_sqy);
        end
    end

    ctpt_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_b3_v),
        .i_sq    (r_b3_sum),
        .i_side  (r_b3_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    always_comb begin
        if (s_side.big || s_root[RT_W-1]) begin
            n_rad = RES_UMAX;
        end else begin
            n_rad = s_root[RES_W-1:0];
        end
        n_clip = s_side.clip | s_side.big | s_root[RT_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            if (s_side.gzero) begin
                r_out_data <= '0;
                r_out_user <= '0;
            end else begin
                r_out_data <= {n_rad, s_side.cy, s_side.cx};
                r_out_user <= {n_clip, 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v  <= 1'b0;
            r_b2_v  <= 1'b0;
            r_b3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (ce) begin
            r_b1_v  <= x_valid;
            r_b2_v  <= r_b1_v;
            r_b3_v  <= r_b2_v;
            r_out_v <= s_valid;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Both dividers must carry the same items in the same stages.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (x_valid == y_valid) && (!x_valid || (x_dz == y_dz)))
        else $error("center dividers out of step");

    // A collinear triple gives an all-zero result.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
        else $error("invalid result carries nonzero fields");

    // The input side is ready exactly when the pipeline can advance.
    a_ready_ties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (m_axis_tready || !m_axis_tvalid))
        else $error("input ready does not follow the output stall");

endmodule

// File: src/ctpt_geom.sv
// Front pipeline: differences, products and the two center numerators plus G.
// Pure arithmetic, five register stages; no package dependency.
module ctpt_geom #(
    parameter int COORD_BITS = 12,
    parameter int NUM_W      = 42,
    parameter int GW         = 28
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ce,
    input  logic                         i_valid,
    input  logic [COORD_BITS-1:0]        i_ax,
    input  logic [COORD_BITS-1:0]        i_ay,
    input  logic [COORD_BITS-1:0]        i_bx,
    input  logic [COORD_BITS-1:0]        i_by,
    input  logic [COORD_BITS-1:0]        i_cx,
    input  logic [COORD_BITS-1:0]        i_cy,
    output logic                         o_valid,
    output logic signed [NUM_W-1:0]      o_num_x,
    output logic signed [NUM_W-1:0]      o_num_y,
    output logic signed [GW-1:0]         o_g,
    output logic [COORD_BITS-1:0]        o_ax,
    output logic [COORD_BITS-1:0]        o_ay
);

    localparam int DW = COORD_BITS + 1;
    localparam int SW = COORD_BITS + 2;
    localparam int PW = DW + SW;
    localparam int QW = 2 * DW;
    localparam int MW = DW + GW;

    logic [4:0] r_v;
    logic [COORD_BITS-1:0] r_ax [0:4];
    logic [COORD_BITS-1:0] r_ay [0:4];

    logic signed [DW-1:0] r1_a, r1_b, r1_c, r1_d, r1_dy, r1_dx;
    logic signed [SW-1:0] r1_sabx, r1_saby, r1_sacx, r1_sacy;
    logic signed [DW-1:0] r2_a, r2_b, r2_c, r2_d;
    logic signed [PW-1:0] r2_pa, r2_pb, r2_pc, r2_pd;
    logic signed [QW-1:0] r2_ga, r2_gb;
    logic signed [DW-1:0] r3_a, r3_b, r3_c, r3_d;
    logic signed [GW-1:0] r3_e, r3_f, r3_g;
    logic signed [MW-1:0] r4_de, r4_bf, r4_af, r4_ce;
    logic signed [GW-1:0] r4_g;
    logic signed [NUM_W-1:0] r5_nx, r5_ny;
    logic signed [GW-1:0] r5_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ax[0] <= i_ax;
            r_ay[0] <= i_ay;
            for (int k = 1; k < 5; k++) begin
                r_ax[k] <= r_ax[k-1];
                r_ay[k] <= r_ay[k-1];
            end
            // Stage 1: point differences and coordinate sums.
            r1_a    <= $signed({1'b0, i_bx}) - $signed({1'b0, i_ax});
            r1_b    <= $signed({1'b0, i_by}) - $signed({1'b0, i_ay});
            r1_c    <= $signed({1'b0, i_cx}) - $signed({1'b0, i_ax});
            r1_d    <= $signed({1'b0, i_cy}) - $signed({1'b0, i_ay});
            r1_dy   <= $signed({1'b0, i_cy}) - $signed({1'b0, i_by});
            r1_dx   <= $signed({1'b0, i_cx}) - $signed({1'b0, i_bx});
            r1_sabx <= $signed({2'b00, i_ax} + {2'b00, i_bx});
            r1_saby <= $signed({2'b00, i_ay} + {2'b00, i_by});
            r1_sacx <= $signed({2'b00, i_ax} + {2'b00, i_cx});
            r1_sacy <= $signed({2'b00, i_ay} + {2'b00, i_cy});
            // Stage 2: first products.
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_c  <= r1_c;
            r2_d  <= r1_d;
            r2_pa <= r1_a * r1_sabx;
            r2_pb <= r1_b * r1_saby;
            r2_pc <= r1_c * r1_sacx;
            r2_pd <= r1_d * r1_sacy;
            r2_ga <= r1_a * r1_dy;
            r2_gb <= r1_b * r1_dx;
            // Stage 3: E, F and G.
            r3_a <= r2_a;
            r3_b <= r2_b;
            r3_c <= r2_c;
            r3_d <= r2_d;
            r3_e <= GW'(r2_pa) + GW'(r2_pb);
            r3_f <= GW'(r2_pc) + GW'(r2_pd);
            r3_g <= (GW'(r2_ga) - GW'(r2_gb)) <<< 1;
            // Stage 4: cross products of the numerators.
            r4_de <= r3_d * r3_e;
            r4_bf <= r3_b * r3_f;
            r4_af <= r3_a * r3_f;
            r4_ce <= r3_c * r3_e;
            r4_g  <= r3_g;
            // Stage 5: numerators.
            r5_nx <= NUM_W'(r4_de) - NUM_W'(r4_bf);
            r5_ny <= NUM_W'(r4_af) - NUM_W'(r4_ce);
            r5_g  <= r4_g;
        end
    end

    assign o_valid = r_v[4];
    assign o_num_x = r5_nx;
    assign o_num_y = r5_ny;
    assign o_g     = r5_g;
    assign o_ax    = r_ax[4];
    assign o_ay    = r_ay[4];

endmodule

// File: src/ctpt_div_pipe.sv
// Pipelined restoring divider: round(num * 2^FRAC_BITS / den), ties away from zero.
// One quotient bit per stage; no package dependency.
module ctpt_div_pipe #(
    parameter int NUM_W     = 42,
    parameter int DEN_W     = 28,
    parameter int FRAC_BITS = 4,
    parameter int SIDE_W    = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_ce,
    input  logic                               i_valid,
    input  logic signed [NUM_W-1:0]            i_num,
    input  logic signed [DEN_W-1:0]            i_den,
    input  logic [SIDE_W-1:0]                  i_side,
    output logic                               o_valid,
    output logic signed [NUM_W+FRAC_BITS+2:0]  o_quo,
    output logic                               o_dzero,
    output logic [SIDE_W-1:0]                  o_side
);

    localparam int DVD_W = NUM_W + FRAC_BITS + 2;
    localparam int DV_W  = DEN_W + 1;
    localparam int ST_W  = DV_W + DVD_W;

    logic [NUM_W-1:0] mag_n;
    logic [DEN_W-1:0] mag_d;

    logic              r_p_v;
    logic [ST_W-1:0]   r_p_st;
    logic [DV_W-1:0]   r_p_dv;
    logic              r_p_neg, r_p_dz;
    logic [SIDE_W-1:0] r_p_side;

    logic [DVD_W-1:0]  r_v;
    logic [ST_W-1:0]   r_st   [0:DVD_W-1];
    logic [DV_W-1:0]   r_dv   [0:DVD_W-1];
    logic              r_neg  [0:DVD_W-1];
    logic              r_dz   [0:DVD_W-1];
    logic [SIDE_W-1:0] r_side [0:DVD_W-1];

    logic                       r_o_v, r_o_dz;
    logic signed [DVD_W:0]      r_o_quo;
    logic [SIDE_W-1:0]          r_o_side;
    logic [DVD_W-1:0]           quo_mag;

    always_comb begin
        mag_n = i_num[NUM_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
        mag_d = i_den[DEN_W-1] ? $unsigned(-i_den) : $unsigned(i_den);
    end

    // Prepare (2n + d) / (2d) so that a floor division rounds to nearest.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_p_st   <= {{DV_W{1'b0}},
                         DVD_W'({mag_n, {(FRAC_BITS + 1){1'b0}}}) + DVD_W'(mag_d)};
            r_p_dv   <= {mag_d, 1'b0};
            r_p_neg  <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_p_dz   <= (i_den == '0);
            r_p_side <= i_side;
        end
    end

    generate
        for (genvar k = 0; k < DVD_W; k++) begin : g_step
            logic [ST_W-1:0]   src_st;
            logic [DV_W-1:0]   src_dv;
            logic              src_neg, src_dz, src_v;
            logic [SIDE_W-1:0] src_side;
            logic [ST_W:0]     sh;
            logic [DV_W:0]     hi;
            logic              qbit;

            if (k == 0) begin : g_first
                assign src_st   = r_p_st;
                assign src_dv   = r_p_dv;
                assign src_neg  = r_p_neg;
                assign src_dz   = r_p_dz;
                assign src_side = r_p_side;
                assign src_v    = r_p_v;
            end else begin : g_next
                assign src_st   = r_st[k-1];
                assign src_dv   = r_dv[k-1];
                assign src_neg  = r_neg[k-1];
                assign src_dz   = r_dz[k-1];
                assign src_side = r_side[k-1];
                assign src_v    = r_v[k-1];
            end

            always_comb begin
                sh   = {src_st, 1'b0};
                hi   = sh[ST_W:DVD_W];
                qbit = 1'b0;
                if (hi >= {1'b0, src_dv}) begin
                    hi   = hi - {1'b0, src_dv};
                    qbit = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_st[k]   <= {hi[DV_W-1:0], sh[DVD_W-1:1], qbit};
                    r_dv[k]   <= src_dv;
                    r_neg[k]  <= src_neg;
                    r_dz[k]   <= src_dz;
                    r_side[k] <= src_side;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_ce) begin
                    r_v[k] <= src_v;
                end
            end
        end
    endgenerate

    assign quo_mag = r_st[DVD_W-1][DVD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_o_quo  <= r_neg[DVD_W-1] ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
            r_o_dz   <= r_dz[DVD_W-1];
            r_o_side <= r_side[DVD_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (i_ce) begin
            r_p_v <= i_valid;
            r_o_v <= r_v[DVD_W-1];
        end
    end

    assign o_valid = r_o_v;
    assign o_quo   = r_o_quo;
    assign o_dzero = r_o_dz;
    assign o_side  = r_o_side;

endmodule

// File: src/ctpt_sqrt_pipe.sv
// Pipelined integer square root rounded to nearest, one root bit per stage.
// Depends on ctpt_pkg for widths and the side-data struct.
module ctpt_sqrt_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_valid,
    input  logic [ctpt_pkg::SQ_W-1:0]     i_sq,
    input  ctpt_pkg::t_rad_side           i_side,
    output logic                          o_valid,
    output logic [ctpt_pkg::RT_W-1:0]     o_root,
    output ctpt_pkg::t_rad_side           o_side
);

    import ctpt_pkg::*;

    logic [RT_W-1:0]  r_v;
    logic [SQ_W-1:0]  r_s    [0:RT_W-1];
    logic [SQ_W-1:0]  r_r    [0:RT_W-1];
    t_rad_side        r_side [0:RT_W-1];

    logic             r_o_v;
    logic [RT_W-1:0]  r_o_root;
    t_rad_side        r_o_side;

    generate
        for (genvar k = 0; k < RT_W; k++) begin : g_step
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (RT_W - 1 - k));
            logic [SQ_W-1:0] src_s, src_r, trial, ns, nr;
            t_rad_side       src_side;
            logic            src_v;

            if (k == 0) begin : g_first
                assign src_s    = i_sq;
                assign src_r    = '0;
                assign src_side = i_side;
                assign src_v    = i_valid;
            end else begin : g_next
                assign src_s    = r_s[k-1];
                assign src_r    = r_r[k-1];
                assign src_side = r_side[k-1];
                assign src_v    = r_v[k-1];
            end

            always_comb begin
                trial = src_r + BIT;
                if (src_s >= trial) begin
                    ns = src_s - trial;
                    nr = (src_r >> 1) + BIT;
                end else begin
                    ns = src_s;
                    nr = src_r >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_s[k]    <= ns;
                    r_r[k]    <= nr;
                    r_side[k] <= src_side;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_ce) begin
                    r_v[k] <= src_v;
                end
            end
        end
    endgenerate

    // The remainder is s - r*r; round up when it exceeds r.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_o_root <= (r_s[RT_W-1] > r_r[RT_W-1]) ? RT_W'(r_r[RT_W-1] + 1'b1)
                                                    : RT_W'(r_r[RT_W-1]);
            r_o_side <= r_side[RT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_ce) begin
            r_o_v <= r_v[RT_W-1];
        end
    end

    assign o_valid = r_o_v;
    assign o_root  = r_o_root;
    assign o_side  = r_o_side;

endmodule
